@@ rtl/shpsel_pkg.sv @@
// Shared types, constants and helpers for the source hash peer selector.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package shpsel_pkg;

   localparam int SLOTS          = 8;
   localparam int IDX_W          = 3;
   localparam int WORD_W         = 32;
   localparam int ENTRY_W        = 64;
   localparam int PROD_W         = 64;
   localparam int ADDR_W         = IDX_W + 3;
   localparam int PEER_COUNT_DEF = 8;

   localparam logic [WORD_W-1:0] MIX_MUL = 32'h6253_1965;
   localparam int                KEY_ROT = 19;
   localparam int                MIX_ROT = 21;

   typedef struct packed {
      logic [7:0] key_char;
      logic       last_char;
      logic [7:0] eligible_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] peer_index;
      logic       found;
   } rsp_type;

   typedef struct packed {
      logic               psel;
      logic               penable;
      logic               pwrite;
      logic [ADDR_W-1:0]  paddr;
      logic [ENTRY_W-1:0] pwdata;
   } apb_cmd_type;

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
      rotl32 = (v << n) | (v >> (WORD_W - n));
   endfunction

endpackage

`default_nettype wire

@@ rtl/shpsel_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on shpsel_pkg.
`default_nettype none

module shpsel_mul (
   input  wire logic                                   clock,
   input  wire logic [shpsel_pkg::WORD_W-1:0]          op_a,
   input  wire logic [shpsel_pkg::WORD_W-1:0]          op_b,
   output logic      [shpsel_pkg::PROD_W-1:0]          prod
);

   logic [shpsel_pkg::PROD_W-1:0] prod_ff;
   logic [shpsel_pkg::PROD_W-1:0] prod_in;

   assign prod_in = shpsel_pkg::PROD_W'(op_a) * shpsel_pkg::PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ rtl/shpsel_regs.sv @@
// Peer entry store: written from the APB port, read back on the APB port
// and at the sequencer's peer index. Depends on shpsel_pkg.
`default_nettype none

module shpsel_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire shpsel_pkg::apb_cmd_type             cmd,
   output logic      [shpsel_pkg::ENTRY_W-1:0]      prdata,
   input  wire logic [shpsel_pkg::IDX_W-1:0]        rd_idx,
   output logic      [shpsel_pkg::ENTRY_W-1:0]      entry
);

   logic [shpsel_pkg::ENTRY_W-1:0] mem [shpsel_pkg::SLOTS];
   logic [shpsel_pkg::SLOTS-1:0]   valid_ff;
   logic [shpsel_pkg::SLOTS-1:0]   valid_in;
   logic [shpsel_pkg::ENTRY_W-1:0] prdata_ff;
   logic [shpsel_pkg::ENTRY_W-1:0] entry_ff;
   logic [shpsel_pkg::IDX_W-1:0]   wr_idx;
   logic                           wr_en;
   logic                           rd_en;

   assign wr_idx = cmd.paddr[shpsel_pkg::ADDR_W-1:3];
   assign wr_en  = cmd.psel & cmd.penable & cmd.pwrite;
   assign rd_en  = cmd.psel & ~cmd.penable & ~cmd.pwrite;
   assign prdata = prdata_ff;
   assign entry  = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= cmd.pwdata;
      end
      if (rd_en) begin
         prdata_ff <= valid_ff[wr_idx] ? mem[wr_idx] : '0;
      end
      entry_ff <= valid_ff[rd_idx] ? mem[rd_idx] : '0;
   end

endmodule

`default_nettype wire

@@ rtl/source_hash_peer_select.sv @@
// Top level: key hash, peer walk sequencer and result register.
// Depends on shpsel_pkg, shpsel_regs and shpsel_mul.
//
//   channel   direction  handshake               payload
//   req       in         req_valid/req_ready     req_type (key_char, last_char, eligible_mask)
//   rsp       out        rsp_valid/rsp_ready     rsp_type (peer_index, found)
//   csr       in/out     APB, csr_pready high    peer entries 0..7 at 8*i
//
// A character without last_char keeps the sequencer idle; such requests go back to back.
// After a last character the walk runs ST_FETCH, then ST_MIX, ST_SUM, ST_SCORE and ST_CMP
// for each peer, then ST_WRITE, which loads the response: each peer makes two passes
// through the shared 32x32 multiplier, with a sum step between them and a compare after.
// Reset is synchronous: it clears the key hash, the sequencer and the entry store.
// The response waits in its register until taken; the walk holds in its last step
// while an earlier response is still pending.
`default_nettype none

module source_hash_peer_select #(
   parameter int PEER_COUNT = shpsel_pkg::PEER_COUNT_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire shpsel_pkg::req_type                    req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output shpsel_pkg::rsp_type                         rsp_data,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [shpsel_pkg::ADDR_W-1:0]          csr_paddr,
   input  wire logic [shpsel_pkg::ENTRY_W-1:0]         csr_pwdata,
   output logic      [shpsel_pkg::ENTRY_W-1:0]         csr_prdata,
   output logic                                        csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MIX,
      ST_SUM,
      ST_SCORE,
      ST_CMP,
      ST_WRITE
   } state_type;

   localparam logic [shpsel_pkg::IDX_W-1:0] LAST_IDX = shpsel_pkg::IDX_W'(PEER_COUNT - 1);

   state_type                           state_ff,    state_in;
   logic [shpsel_pkg::WORD_W-1:0]       key_ff,      key_in;
   logic [shpsel_pkg::IDX_W-1:0]        idx_ff,      idx_in;
   logic [7:0]                          elig_ff,     elig_in;
   logic [shpsel_pkg::WORD_W-1:0]       mixed_ff,    mixed_in;
   logic [shpsel_pkg::WORD_W-1:0]       comb_ff,     comb_in;
   logic [shpsel_pkg::PROD_W-1:0]       best_ff,     best_in;
   logic [shpsel_pkg::IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic                                found_ff,    found_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   shpsel_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   shpsel_pkg::apb_cmd_type             cmd;
   logic [shpsel_pkg::ENTRY_W-1:0]      entry;
   logic [shpsel_pkg::WORD_W-1:0]       peer_hash;
   logic [shpsel_pkg::WORD_W-1:0]       peer_mult;
   logic [shpsel_pkg::WORD_W-1:0]       op_a;
   logic [shpsel_pkg::WORD_W-1:0]       op_b;
   logic [shpsel_pkg::PROD_W-1:0]       prod;
   logic                                req_fire;
   logic                                out_free;

   assign cmd.psel    = csr_psel;
   assign cmd.penable = csr_penable;
   assign cmd.pwrite  = csr_pwrite;
   assign cmd.paddr   = csr_paddr;
   assign cmd.pwdata  = csr_pwdata;
   assign csr_pready  = 1'b1;

   assign peer_hash = entry[shpsel_pkg::ENTRY_W-1:shpsel_pkg::WORD_W];
   assign peer_mult = entry[shpsel_pkg::WORD_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   shpsel_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .prdata (csr_prdata),
      .rd_idx (idx_in),
      .entry  (entry)
   );

   shpsel_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   always_comb begin
      if (state_ff == ST_MIX) begin
         op_a = mixed_in;
         op_b = shpsel_pkg::MIX_MUL;
      end else begin
         op_a = comb_ff;
         op_b = peer_mult;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      elig_in      = elig_ff;
      mixed_in     = key_ff ^ peer_hash;
      comb_in      = comb_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               key_in = key_ff + shpsel_pkg::rotl32(key_ff, shpsel_pkg::KEY_ROT)
                        + shpsel_pkg::WORD_W'(req_data.key_char);
               if (req_data.last_char) begin
                  elig_in     = req_data.eligible_mask;
                  best_in     = '0;
                  best_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            comb_in  = shpsel_pkg::rotl32(mixed_ff + prod[shpsel_pkg::WORD_W-1:0],
                                          shpsel_pkg::MIX_ROT);
            state_in = ST_SCORE;
         end
         ST_SCORE: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((prod > best_ff) && elig_ff[idx_ff]) begin
               best_in     = prod;
               best_idx_in = idx_ff;
               found_in    = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               key_in   = '0;
               idx_in   = '0;
               state_in = ST_WRITE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MIX;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.peer_index = best_idx_ff;
               rsp_data_in.found      = found_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elig_ff     <= elig_in;
      mixed_ff    <= (state_ff == ST_MIX) ? mixed_in : mixed_ff;
      comb_ff     <= comb_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ rtl/shpsel_checker.sv @@
// Port-level checks for source_hash_peer_select, attached by bind.
// Depends on shpsel_pkg and the top level's ports.
`default_nettype none

module shpsel_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire shpsel_pkg::req_type                 req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire shpsel_pkg::rsp_type                 rsp_data,
   input  wire logic                                pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_not_found_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.peer_index == 3'd0)
      else $error("not-found response carries a nonzero peer index");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_char |=> !req_ready)
      else $error("request taken right after a last character");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind source_hash_peer_select shpsel_checker u_shpsel_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (csr_pready)
);

`default_nettype wire

@@ bench/source_hash_peer_select_test.sv @@
// Self-checking bench for source_hash_peer_select: key characters in, peer picks out.
// Needs shpsel_pkg and the RTL under rtl; a scoreboard class predicts each pick.
`default_nettype none

module source_hash_peer_select_test;

   localparam int PEERS       = shpsel_pkg::PEER_COUNT_DEF;
   localparam int ENTRY_BYTES = 8;
   localparam int SETTLE      = 2 + 4 * PEERS + 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 150;
   localparam int REPORT_MAX  = 10;

   typedef enum {
      FILL_RANDOM,
      FILL_EQUAL,
      FILL_ALL_ONES,
      FILL_ZERO,
      FILL_SPARSE,
      FILL_LOW_WEIGHT
   } fill_type;

   class pick_board_type;
      logic [shpsel_pkg::ENTRY_W-1:0] peer_entry [shpsel_pkg::SLOTS];
      logic [shpsel_pkg::WORD_W-1:0]  key_hash;
      shpsel_pkg::rsp_type            pending_picks [$];
      int                             mismatches;

      function new();
         foreach (peer_entry[i]) peer_entry[i] = '0;
         key_hash   = '0;
         mismatches = 0;
      endfunction

      function logic [shpsel_pkg::WORD_W-1:0] rot_left(logic [shpsel_pkg::WORD_W-1:0] v,
                                                       int unsigned n);
         return (v << n) | (v >> (shpsel_pkg::WORD_W - n));
      endfunction

      function logic [shpsel_pkg::WORD_W-1:0] mix_key(logic [shpsel_pkg::WORD_W-1:0] key,
                                                      logic [shpsel_pkg::WORD_W-1:0] peer_hash);
         logic [shpsel_pkg::WORD_W-1:0] m;
         m = key ^ peer_hash;
         m = m + m * shpsel_pkg::MIX_MUL;
         return rot_left(m, shpsel_pkg::MIX_ROT);
      endfunction

      function void set_peer(int unsigned idx, logic [shpsel_pkg::ENTRY_W-1:0] value);
         peer_entry[idx] = value;
      endfunction

      function void note_request(shpsel_pkg::req_type r);
         shpsel_pkg::rsp_type            pick;
         logic [shpsel_pkg::PROD_W-1:0]  best;
         logic [shpsel_pkg::PROD_W-1:0]  score;
         logic [shpsel_pkg::WORD_W-1:0]  mixed;
         key_hash = key_hash + rot_left(key_hash, shpsel_pkg::KEY_ROT) + 32'(r.key_char);
         if (!r.last_char) return;
         best = '0;
         pick = '0;
         for (int i = 0; i < PEERS; i++) begin
            mixed = mix_key(key_hash, peer_entry[i][63:32]);
            score = {32'b0, mixed} * {32'b0, peer_entry[i][31:0]};
            if (score > best && r.eligible_mask[i]) begin
               best            = score;
               pick.peer_index = 3'(i);
               pick.found      = 1'b1;
            end
         end
         pending_picks = {pending_picks, pick};
         key_hash = '0;
      endfunction

      function void flag(string what, int wanted, int got);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, wanted, got);
      endfunction

      function void check_response(shpsel_pkg::rsp_type got);
         shpsel_pkg::rsp_type wanted;
         if (pending_picks.size() == 0) begin
            flag("unrequested response, peer_index", -1, got.peer_index);
            return;
         end
         wanted = pending_picks.pop_front();
         if (got.peer_index !== wanted.peer_index)
            flag("peer_index", wanted.peer_index, got.peer_index);
         if (got.found !== wanted.found)
            flag("found", wanted.found, got.found);
      endfunction

      function int pending();
         return pending_picks.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   shpsel_pkg::req_type             req_data;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   shpsel_pkg::rsp_type             rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [shpsel_pkg::ADDR_W-1:0]   paddr;
   logic [shpsel_pkg::ENTRY_W-1:0]  pwdata;
   logic [shpsel_pkg::ENTRY_W-1:0]  prdata;
   logic                            pready;

   pick_board_type      board;
   int                  cycle_count = 0;
   int                  stall_left  = 0;
   bit                  steady      = 1'b0;

   source_hash_peer_select #(.PEER_COUNT(PEERS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** source_hash_peer_select: FAILED **");
      $finish;
   end

   task automatic send_request(input shpsel_pkg::req_type r);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_char(input logic [7:0] c, input logic last, input logic [7:0] mask);
      send_request('{key_char: c, last_char: last, eligible_mask: mask});
   endtask

   task automatic send_random_key(input int len);
      logic [7:0] mask;
      for (int j = 0; j < len; j++) begin
         case ($urandom_range(0, 7))
            0:       mask = 8'hFF;
            1:       mask = 8'h00;
            2:       mask = 8'(1 << $urandom_range(0, 7));
            default: mask = 8'($urandom);
         endcase
         send_char(8'($urandom_range(0, 255)), j == len - 1, mask);
      end
   endtask

   // hold the sender until every pick is back; optionally let a walk finish
   task automatic drain_requests(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      if (settle) repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_peer(input int unsigned idx,
                             input logic [shpsel_pkg::ENTRY_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= shpsel_pkg::ADDR_W'(idx * ENTRY_BYTES);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_peer(idx, value);
   endtask

   task automatic load_peers(input fill_type kind);
      logic [shpsel_pkg::ENTRY_W-1:0] shared;
      logic [shpsel_pkg::ENTRY_W-1:0] value;
      logic [shpsel_pkg::WORD_W-1:0]  hash_word;
      logic [shpsel_pkg::WORD_W-1:0]  mul_word;
      shared = {$urandom, $urandom};
      for (int i = 0; i < shpsel_pkg::SLOTS; i++) begin
         case (kind)
            FILL_RANDOM:   value = {$urandom, $urandom};
            FILL_EQUAL:    value = shared;
            FILL_ALL_ONES: value = '1;
            FILL_ZERO:     value = '0;
            FILL_SPARSE: begin
               case ($urandom_range(0, 3))
                  0:       hash_word = '0;
                  1:       hash_word = '1;
                  default: hash_word = $urandom;
               endcase
               case ($urandom_range(0, 3))
                  0:       mul_word = '0;
                  1:       mul_word = 32'h0001_0000;
                  2:       mul_word = '1;
                  default: mul_word = $urandom;
               endcase
               value = {hash_word, mul_word};
            end
            FILL_LOW_WEIGHT: begin
               if (i % 2 == 0) shared = {$urandom, 32'($urandom_range(0, 3))};
               value = shared;
            end
            default: value = '0;
         endcase
         write_peer(i, value);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      fill_type phase_plan [7];
      int       sent;
      string    addr;
      board      = new();
      phase_plan = '{FILL_RANDOM, FILL_SPARSE, FILL_EQUAL, FILL_LOW_WEIGHT,
                     FILL_ALL_ONES, FILL_ZERO, FILL_RANDOM};
      addr       = "10.0.0.1";
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all entries still zero after reset: nothing can win
      send_char(8'h31, 1'b0, 8'h00);
      send_char(8'h30, 1'b1, 8'hFF);
      drain_requests(1'b1);

      load_peers(FILL_ALL_ONES);
      send_char(8'hFF, 1'b1, 8'hFF);
      send_char(8'h00, 1'b1, 8'h80);
      send_char(8'h7F, 1'b1, 8'h00);
      drain_requests(1'b1);

      load_peers(FILL_RANDOM);
      send_char(8'h00, 1'b1, 8'hFF);
      send_char(8'hFF, 1'b0, 8'h00);
      send_char(8'h80, 1'b0, 8'hFF);
      send_char(8'h01, 1'b1, 8'h01);
      send_char(8'h55, 1'b1, 8'h55);
      send_char(8'hAA, 1'b1, 8'hAA);
      foreach (addr[k]) send_char(addr[k], k == addr.len() - 1, 8'hFF);

      foreach (phase_plan[p]) begin
         drain_requests(1'b1);
         load_peers(phase_plan[p]);
         steady = (p == $size(phase_plan) - 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (p == 0 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 16)
               drain_requests(1'b0);
            if ($urandom_range(0, 7) == 0) begin
               send_random_key(1);
               sent += 1;
            end else begin
               int len;
               len = $urandom_range(2, 15);
               send_random_key(len);
               sent += len;
            end
         end
      end

      drain_requests(1'b1);
      @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("** source_hash_peer_select: PASSED **");
      else
         $display("** source_hash_peer_select: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
